// ----- design/two_operator_fm_voice_core_defines.svh -----
// Assertion macros shared by the FM voice RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef TWO_OPERATOR_FM_VOICE_CORE_DEFINES_SVH
`define TWO_OPERATOR_FM_VOICE_CORE_DEFINES_SVH
`ifndef SYNTH
// Checked property, switched off while reset is held.
`define TOFMV_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("tofmv assertion failed");
// Checked property that also holds through reset.
`define TOFMV_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tofmv assertion failed");
`else
`define TOFMV_ASSERT(lbl, clk, rstn, prop)
`define TOFMV_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- design/tofmv_pkg.sv -----
// Types, constants, sine table and sine lookup for the FM voice.
// No dependencies; imported by every module of the block.
package tofmv_pkg;

    localparam int PHASE_W     = 32;
    localparam int IN_W        = 16;
    localparam int SAMPLE_W    = 16;
    localparam int SINE_IDX_W  = 10;
    localparam int SINE_ENTRIES = 1 << SINE_IDX_W;
    localparam int QTAB_DEPTH  = SINE_ENTRIES / 4;
    localparam int QTAB_IDX_W  = SINE_IDX_W - 2;
    localparam int SINE_MAG_W  = SAMPLE_W - 1;
    localparam int FREQ_W      = 31;
    localparam int DEPTH_W     = 27;
    localparam int RATIO_W     = 16;
    localparam int MAXDEV_W    = 20;
    localparam int COEFF_W     = 16;
    localparam int PPH_W       = 17;
    localparam int CFG_DATA_W  = 31;
    localparam int CFG_IDX_W   = 3;
    localparam int MUL_A_W     = 37;
    localparam int MUL_B_W     = 27;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int CF_W        = 34;
    localparam int CFMAG_W     = CF_W - 1;
    localparam int MFMAG_W     = 37;

    localparam logic [FREQ_W-1:0]  RST_BASE_FREQ  = 31'd8519680;
    localparam logic [FREQ_W-1:0]  RST_FREQ_SPAN  = 31'd24248320;
    localparam logic [DEPTH_W-1:0] RST_VIB_DEPTH  = 27'd983040;
    localparam logic [FREQ_W-1:0]  RST_LFO_STEP   = 31'd340871;
    localparam logic [RATIO_W-1:0] RST_MOD_RATIO  = 16'd6144;
    localparam logic [MAXDEV_W-1:0] RST_MAX_DEV   = 20'd52154;
    localparam logic [COEFF_W-1:0] RST_SMOOTH_CF  = 16'd33;
    localparam logic [PPH_W-1:0]   RST_PHASE_PER_HZ = 17'd97392;
    localparam logic [PHASE_W-1:0] RST_SMOOTH_FREQ  = 32'd8519680;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] AMP_MAX     = 64'd32767;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_FREQ     = 3'd0,
        CFG_FREQ_SPAN     = 3'd1,
        CFG_VIBRATO_DEPTH = 3'd2,
        CFG_LFO_STEP      = 3'd3,
        CFG_MOD_RATIO     = 3'd4,
        CFG_MAX_DEVIATION = 3'd5,
        CFG_SMOOTH_COEFF  = 3'd6,
        CFG_PHASE_PER_HZ  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic                  en;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_TGT, ST_TGT, ST_DIFF, ST_SMUL, ST_SMOOTH, ST_CF, ST_CFMAG,
        ST_MUL_RATIO, ST_MF, ST_CSTEP, ST_MSTEP, ST_MSINE, ST_MUL_DEV, ST_TOT, ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_MUL_TGT, OP_TGT, OP_DIFF, OP_SMUL, OP_SMOOTH, OP_CF,
        OP_CFMAG, OP_MUL_RATIO, OP_MF, OP_CSTEP, OP_MSTEP, OP_MSINE, OP_MUL_DEV,
        OP_TOT, OP_OUT
    } t_op;

    typedef struct packed {
        logic                  neg;
        logic [SINE_MAG_W-1:0] mag;
    } t_sine;

    typedef logic [QTAB_DEPTH-1:0][SINE_MAG_W-1:0] t_qtab;

    // Quarter-wave magnitudes for table positions 1 to QTAB_DEPTH; position
    // zero is exactly zero and is not stored. Evaluated at elaboration only.
    function automatic t_qtab build_qtab();
        t_qtab       tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        for (int j = 1; j <= QTAB_DEPTH; j++) begin
            x  = (64'(4 * j) * HALF_PI_Q30) / SINE_ENTRIES;
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            t  = Q30_ONE - ((x2 * t) >> 30) / 110;
            t  = Q30_ONE - ((x2 * t) >> 30) / 72;
            t  = Q30_ONE - ((x2 * t) >> 30) / 42;
            t  = Q30_ONE - ((x2 * t) >> 30) / 20;
            t  = Q30_ONE - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            v  = (s * AMP_MAX + (Q30_ONE >> 1)) >> 30;
            if (v > AMP_MAX) begin
                v = AMP_MAX;
            end
            tab[j-1] = v[SINE_MAG_W-1:0];
        end
        return tab;
    endfunction

    localparam t_qtab QTAB = build_qtab();

    // Full-wave sine from the quarter table: the top two index bits pick the
    // quadrant, odd quadrants read the table mirrored.
    function automatic t_sine sine_at(input logic [PHASE_W-1:0] phase);
        logic [SINE_IDX_W-1:0] idx;
        logic [QTAB_IDX_W-1:0] r;
        logic [QTAB_IDX_W-1:0] pos;
        logic                  zero;
        t_sine                 res;
        idx = phase[PHASE_W-1 -: SINE_IDX_W];
        r   = idx[QTAB_IDX_W-1:0];
        if (idx[QTAB_IDX_W]) begin
            pos  = ~r;
            zero = 1'b0;
        end else begin
            pos  = r - 1'b1;
            zero = (r == '0);
        end
        res.neg = idx[SINE_IDX_W-1];
        res.mag = zero ? '0 : QTAB[pos];
        return res;
    endfunction

endpackage

// ----- design/tofmv_datapath.sv -----
// Datapath of the FM voice: configuration registers, voice state, one shared
// multiplier and the sine lookups. Depends on tofmv_pkg; driven by tofmv_ctrl.
module tofmv_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tofmv_pkg::t_op                       i_op,
    input  tofmv_pkg::t_cfg_wr                   i_cfg,
    input  logic [tofmv_pkg::IN_W-1:0]           i_pitch,
    input  logic [tofmv_pkg::IN_W-1:0]           i_bright,
    input  logic                                 i_last,
    output logic signed [tofmv_pkg::SAMPLE_W-1:0] o_sample,
    output logic                                 o_last
);
    import tofmv_pkg::*;

    // Configuration
    logic [FREQ_W-1:0]   r_base_freq;
    logic [FREQ_W-1:0]   r_freq_span;
    logic [DEPTH_W-1:0]  r_vib_depth;
    logic [FREQ_W-1:0]   r_lfo_step;
    logic [RATIO_W-1:0]  r_mod_ratio;
    logic [MAXDEV_W-1:0] r_max_dev;
    logic [COEFF_W-1:0]  r_smooth_coeff;
    logic [PPH_W-1:0]    r_phase_per_hz;

    // Voice state
    logic [PHASE_W-1:0] r_smooth, n_smooth;
    logic [PHASE_W-1:0] r_lfo_ph, n_lfo_ph;
    logic [PHASE_W-1:0] r_car_ph, n_car_ph;
    logic [PHASE_W-1:0] r_mod_ph, n_mod_ph;

    // Working registers
    logic [IN_W-1:0]     r_pitch, n_pitch;
    logic [IN_W-1:0]     r_bright, n_bright;
    logic                r_last, n_last;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [PHASE_W-1:0]  r_target, n_target;
    logic [MAXDEV_W-1:0] r_idx, n_idx;
    t_sine               r_lfo, n_lfo;
    logic                r_up, n_up;
    logic [PHASE_W-1:0]  r_diff, n_diff;
    logic [DEPTH_W-1:0]  r_vib, n_vib;
    logic [CF_W-1:0]     r_cf, n_cf;
    logic                r_cfneg, n_cfneg;
    logic [CFMAG_W-1:0]  r_cfmag, n_cfmag;
    logic [MFMAG_W-1:0]  r_mfmag, n_mfmag;
    t_sine               r_s, n_s;
    logic [PHASE_W-1:0]  r_tot, n_tot;
    logic signed [SAMPLE_W-1:0] r_sample, n_sample;
    logic                r_out_last, n_out_last;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PHASE_W:0]   sub_up;
    logic [PHASE_W-1:0] sub_dn;
    logic [CF_W-1:0]    cf_negated;
    logic [PHASE_W-1:0] dev;
    t_sine              out_sine;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_freq    <= RST_BASE_FREQ;
            r_freq_span    <= RST_FREQ_SPAN;
            r_vib_depth    <= RST_VIB_DEPTH;
            r_lfo_step     <= RST_LFO_STEP;
            r_mod_ratio    <= RST_MOD_RATIO;
            r_max_dev      <= RST_MAX_DEV;
            r_smooth_coeff <= RST_SMOOTH_CF;
            r_phase_per_hz <= RST_PHASE_PER_HZ;
        end else if (i_cfg.en) begin
            case (i_cfg.idx)
                CFG_BASE_FREQ:     r_base_freq    <= i_cfg.data;
                CFG_FREQ_SPAN:     r_freq_span    <= i_cfg.data;
                CFG_VIBRATO_DEPTH: r_vib_depth    <= i_cfg.data[DEPTH_W-1:0];
                CFG_LFO_STEP:      r_lfo_step     <= i_cfg.data;
                CFG_MOD_RATIO:     r_mod_ratio    <= i_cfg.data[RATIO_W-1:0];
                CFG_MAX_DEVIATION: r_max_dev      <= i_cfg.data[MAXDEV_W-1:0];
                CFG_SMOOTH_COEFF:  r_smooth_coeff <= i_cfg.data[COEFF_W-1:0];
                CFG_PHASE_PER_HZ:  r_phase_per_hz <= i_cfg.data[PPH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= RST_SMOOTH_FREQ;
            r_lfo_ph <= '0;
            r_car_ph <= '0;
            r_mod_ph <= '0;
        end else begin
            r_smooth <= n_smooth;
            r_lfo_ph <= n_lfo_ph;
            r_car_ph <= n_car_ph;
            r_mod_ph <= n_mod_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pitch    <= n_pitch;
        r_bright   <= n_bright;
        r_last     <= n_last;
        r_prod     <= n_prod;
        r_target   <= n_target;
        r_idx      <= n_idx;
        r_lfo      <= n_lfo;
        r_up       <= n_up;
        r_diff     <= n_diff;
        r_vib      <= n_vib;
        r_cf       <= n_cf;
        r_cfneg    <= n_cfneg;
        r_cfmag    <= n_cfmag;
        r_mfmag    <= n_mfmag;
        r_s        <= n_s;
        r_tot      <= n_tot;
        r_sample   <= n_sample;
        r_out_last <= n_out_last;
    end

    // Each multiply is issued in the step before the one that consumes r_prod.
    always_comb begin
        n_smooth   = r_smooth;
        n_lfo_ph   = r_lfo_ph;
        n_car_ph   = r_car_ph;
        n_mod_ph   = r_mod_ph;
        n_pitch    = r_pitch;
        n_bright   = r_bright;
        n_last     = r_last;
        n_target   = r_target;
        n_idx      = r_idx;
        n_lfo      = r_lfo;
        n_up       = r_up;
        n_diff     = r_diff;
        n_vib      = r_vib;
        n_cf       = r_cf;
        n_cfneg    = r_cfneg;
        n_cfmag    = r_cfmag;
        n_mfmag    = r_mfmag;
        n_s        = r_s;
        n_tot      = r_tot;
        n_sample   = r_sample;
        n_out_last = r_out_last;
        mul_a      = '0;
        mul_b      = '0;
        sub_up     = {1'b0, r_target} - {1'b0, r_smooth};
        sub_dn     = r_smooth - r_target;
        cf_negated = -r_cf;
        dev        = {r_prod[30:15], 16'b0};
        out_sine   = sine_at(r_tot);
        case (i_op)
            OP_LOAD: begin
                n_pitch  = i_pitch;
                n_bright = i_bright;
                n_last   = i_last;
            end
            OP_MUL_TGT: begin
                mul_a    = MUL_A_W'(r_freq_span);
                mul_b    = MUL_B_W'(r_pitch);
                n_lfo_ph = r_lfo_ph + PHASE_W'(r_lfo_step);
            end
            OP_TGT: begin
                // Base plus span fits in 32 bits, so the target never clips.
                n_target = PHASE_W'({1'b0, r_base_freq} + {1'b0, r_prod[46:16]});
                mul_a    = MUL_A_W'(r_max_dev);
                mul_b    = MUL_B_W'(r_bright);
                n_lfo    = sine_at(r_lfo_ph);
            end
            OP_DIFF: begin
                n_up   = !sub_up[PHASE_W];
                n_diff = sub_up[PHASE_W] ? sub_dn : sub_up[PHASE_W-1:0];
                n_idx  = r_prod[35:16];
                mul_a  = MUL_A_W'(r_lfo.mag);
                mul_b  = r_vib_depth;
            end
            OP_SMUL: begin
                n_vib = r_prod[41:15];
                mul_a = MUL_A_W'(r_diff);
                mul_b = MUL_B_W'(r_smooth_coeff);
            end
            OP_SMOOTH: begin
                n_smooth = r_up ? r_smooth + r_prod[47:16] : r_smooth - r_prod[47:16];
            end
            OP_CF: begin
                n_cf = r_lfo.neg ? {2'b0, r_smooth} - {7'b0, r_vib}
                                 : {2'b0, r_smooth} + {7'b0, r_vib};
            end
            OP_CFMAG: begin
                n_cfneg = r_cf[CF_W-1];
                n_cfmag = r_cf[CF_W-1] ? cf_negated[CFMAG_W-1:0] : r_cf[CFMAG_W-1:0];
            end
            OP_MUL_RATIO: begin
                mul_a = MUL_A_W'(r_cfmag);
                mul_b = MUL_B_W'(r_mod_ratio);
            end
            OP_MF: begin
                n_mfmag = r_prod[48:12];
                mul_a   = MUL_A_W'(r_cfmag);
                mul_b   = MUL_B_W'(r_phase_per_hz);
            end
            OP_CSTEP: begin
                // The modulator runs in the same direction as the carrier.
                n_car_ph = r_cfneg ? r_car_ph - r_prod[47:16] : r_car_ph + r_prod[47:16];
                mul_a    = r_mfmag;
                mul_b    = MUL_B_W'(r_phase_per_hz);
            end
            OP_MSTEP: begin
                n_mod_ph = r_cfneg ? r_mod_ph - r_prod[47:16] : r_mod_ph + r_prod[47:16];
            end
            OP_MSINE: begin
                n_s = sine_at(r_mod_ph);
            end
            OP_MUL_DEV: begin
                mul_a = MUL_A_W'(r_idx);
                mul_b = MUL_B_W'(r_s.mag);
            end
            OP_TOT: begin
                n_tot = r_s.neg ? r_car_ph - dev : r_car_ph + dev;
            end
            OP_OUT: begin
                n_sample   = out_sine.neg ? -$signed({1'b0, out_sine.mag})
                                          : $signed({1'b0, out_sine.mag});
                n_out_last = r_last;
            end
            default: ;
        endcase
        n_prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    assign o_sample = r_sample;
    assign o_last   = r_out_last;

endmodule

// ----- design/tofmv_ctrl.sv -----
// Sequencer of the FM voice: steps the datapath through one sample and owns
// both stream handshakes. Depends on tofmv_pkg and the assertion macro header.
`include "two_operator_fm_voice_core_defines.svh"
module tofmv_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output tofmv_pkg::t_op o_op
);
    import tofmv_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_m_tready;
        o_op        = OP_NONE;
        o_s_tready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // A new tick is taken even while the last sample waits, but
                // never while reset is held.
                o_s_tready = i_rst_n;
                if (i_s_tvalid && i_rst_n) begin
                    o_op    = OP_LOAD;
                    n_state = ST_MUL_TGT;
                end
            end
            ST_MUL_TGT: begin
                o_op    = OP_MUL_TGT;
                n_state = ST_TGT;
            end
            ST_TGT: begin
                o_op    = OP_TGT;
                n_state = ST_DIFF;
            end
            ST_DIFF: begin
                o_op    = OP_DIFF;
                n_state = ST_SMUL;
            end
            ST_SMUL: begin
                o_op    = OP_SMUL;
                n_state = ST_SMOOTH;
            end
            ST_SMOOTH: begin
                o_op    = OP_SMOOTH;
                n_state = ST_CF;
            end
            ST_CF: begin
                o_op    = OP_CF;
                n_state = ST_CFMAG;
            end
            ST_CFMAG: begin
                o_op    = OP_CFMAG;
                n_state = ST_MUL_RATIO;
            end
            ST_MUL_RATIO: begin
                o_op    = OP_MUL_RATIO;
                n_state = ST_MF;
            end
            ST_MF: begin
                o_op    = OP_MF;
                n_state = ST_CSTEP;
            end
            ST_CSTEP: begin
                o_op    = OP_CSTEP;
                n_state = ST_MSTEP;
            end
            ST_MSTEP: begin
                o_op    = OP_MSTEP;
                n_state = ST_MSINE;
            end
            ST_MSINE: begin
                o_op    = OP_MSINE;
                n_state = ST_MUL_DEV;
            end
            ST_MUL_DEV: begin
                o_op    = OP_MUL_DEV;
                n_state = ST_TOT;
            end
            ST_TOT: begin
                o_op    = OP_TOT;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    o_op        = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;

    `TOFMV_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (r_state == ST_IDLE && !r_out_valid))
    `TOFMV_ASSERT(a_accept_starts, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) |=> (r_state == ST_MUL_TGT))
    `TOFMV_ASSERT(a_steps_advance, i_clk, i_rst_n, (r_state != ST_IDLE && r_state != ST_OUT) |=> (r_state != $past(r_state)))
    `TOFMV_ASSERT(a_issue_done, i_clk, i_rst_n, (r_state == ST_OUT && (!r_out_valid || i_m_tready)) |=> (r_out_valid && r_state == ST_IDLE))
    `TOFMV_ASSERT(a_result_from_out, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == ST_OUT))

endmodule

// ----- design/two_operator_fm_voice_core.sv -----
// Two-operator FM voice, one 16-bit sample per input tick.
// The sequencer steps the single shared multiplier through every product of
// the sample in turn, so a new tick is taken only back in idle; the output
// step stalls while the previous sample still waits to be taken.
// Reset (synchronous, active low) restores the default registers, sets the
// smoothed frequency to 130 Hz and clears the three phase accumulators.
module two_operator_fm_voice_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] pitch_ctrl, [31:16] bright_ctrl
    input  logic        s_axis_tlast,   // block_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] audio_sample (signed)
    output logic        m_axis_tlast,   // block_last
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [tofmv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tofmv_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tofmv_pkg::*;

    t_op                        op;
    t_cfg_wr                    cfg_wr;
    logic signed [SAMPLE_W-1:0] sample;

    // Register writes are refused while reset is held, as reset would drop them.
    assign o_cfg_ready = i_rst_n;
    assign cfg_wr.en   = i_cfg_valid;
    assign cfg_wr.idx  = t_cfg_idx'(i_cfg_index);
    assign cfg_wr.data = i_cfg_data;

    tofmv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_op       (op)
    );

    tofmv_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (op),
        .i_cfg    (cfg_wr),
        .i_pitch  (s_axis_tdata[15:0]),
        .i_bright (s_axis_tdata[31:16]),
        .i_last   (s_axis_tlast),
        .o_sample (sample),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = sample;

endmodule

// ----- tb/sv/tb_two_operator_fm_voice_core.sv -----
// Self-checking testbench for the two-operator FM voice core.
// Depends on tofmv_pkg and two_operator_fm_voice_core; a scoreboard class predicts
// every sample bit for bit; tasks drive the tick and config buses, a process the ready.
module tb_two_operator_fm_voice_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tofmv_pkg::*;

    localparam int LUT_SIZE      = 1024;
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_AT       = 500;
    localparam int HOLD_CYCLES   = 320;
    localparam int TAIL_CYCLES   = 32;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TICKS   = 154;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } fm_result_t;

    typedef logic [30:0] reg_set_t [8];

    class fm_voice_scoreboard;
        int          sine_lut [LUT_SIZE];
        logic [30:0] base_freq;
        logic [30:0] freq_span;
        logic [26:0] vib_depth;
        logic [30:0] lfo_step;
        logic [15:0] mod_ratio;
        logic [19:0] max_dev;
        logic [15:0] smooth_coeff;
        logic [16:0] phase_per_hz;
        logic [63:0] smooth_freq;
        logic [31:0] lfo_phase;
        logic [31:0] carrier_phase;
        logic [31:0] mod_phase;
        fm_result_t  expected_q [$];
        int          errors;
        int          checked;

        function new();
            build_sine_lut();
            base_freq     = 31'd8519680;
            freq_span     = 31'd24248320;
            vib_depth     = 27'd983040;
            lfo_step      = 31'd340871;
            mod_ratio     = 16'd6144;
            max_dev       = 20'd52154;
            smooth_coeff  = 16'd33;
            phase_per_hz  = 17'd97392;
            smooth_freq   = 64'd8519680;
            lfo_phase     = '0;
            carrier_phase = '0;
            mod_phase     = '0;
            errors        = 0;
            checked       = 0;
        endfunction

        // Quarter-wave sine in Q2.30 from a Taylor series through x^11.
        function logic [63:0] quarter_wave(logic [63:0] u);
            int          divs [5] = '{110, 72, 42, 20, 6};
            logic [63:0] x;
            logic [63:0] x2;
            logic [63:0] t;
            x  = (u * 64'd1686629713) / LUT_SIZE;
            x2 = (x * x) >> 30;
            t  = 64'd1 << 30;
            for (int i = 0; i < 5; i++) begin
                t = (64'd1 << 30) - ((x2 * t) >> 30) / divs[i];
            end
            return (x * t) >> 30;
        endfunction

        function void build_sine_lut();
            logic [63:0] quad;
            logic [63:0] rem;
            logic [63:0] s;
            logic [63:0] v;
            for (int k = 0; k < LUT_SIZE; k++) begin
                quad = 64'(k) * 4 / LUT_SIZE;
                rem  = 64'(k) * 4 - quad * LUT_SIZE;
                s    = quad[0] ? quarter_wave(LUT_SIZE - rem) : quarter_wave(rem);
                v    = (s * 64'd32767 + (64'd1 << 29)) >> 30;
                if (v > 64'd32767) begin
                    v = 64'd32767;
                end
                sine_lut[k] = (quad >= 2) ? -int'(v) : int'(v);
            end
        endfunction

        function longint sine_of(logic [31:0] phase);
            return sine_lut[phase[31:22]];
        endfunction

        // Signed by unsigned product, shifted, truncated toward zero.
        function longint scaled_product(longint a, logic [63:0] b, int sh);
            logic [63:0] mag;
            logic [63:0] r;
            mag = (a < 0) ? 64'(-a) : 64'(a);
            r   = (mag * b) >> sh;
            return (a < 0) ? -longint'(r) : longint'(r);
        endfunction

        function void set_register(t_cfg_idx idx, logic [30:0] value);
            case (idx)
                CFG_BASE_FREQ:     base_freq    = value;
                CFG_FREQ_SPAN:     freq_span    = value;
                CFG_VIBRATO_DEPTH: vib_depth    = value[26:0];
                CFG_LFO_STEP:      lfo_step     = value;
                CFG_MOD_RATIO:     mod_ratio    = value[15:0];
                CFG_MAX_DEVIATION: max_dev      = value[19:0];
                CFG_SMOOTH_COEFF:  smooth_coeff = value[15:0];
                CFG_PHASE_PER_HZ:  phase_per_hz = value[16:0];
                default: ;
            endcase
        endfunction

        function void note_tick(logic [15:0] pitch, logic [15:0] bright, logic last);
            logic [63:0] target;
            logic [63:0] depth_idx;
            logic [63:0] dev;
            logic [31:0] total;
            longint      lfo;
            longint      cf;
            longint      mf;
            longint      s;
            longint      v;
            fm_result_t  res;
            target = 64'(base_freq) + ((64'(freq_span) * 64'(pitch)) >> 16);
            if (target > 64'hFFFF_FFFF) begin
                target = 64'hFFFF_FFFF;
            end
            if (target >= smooth_freq) begin
                smooth_freq = smooth_freq + (((target - smooth_freq) * 64'(smooth_coeff)) >> 16);
            end else begin
                smooth_freq = smooth_freq - (((smooth_freq - target) * 64'(smooth_coeff)) >> 16);
            end
            lfo_phase = lfo_phase + 32'(lfo_step);
            lfo = sine_of(lfo_phase);
            cf  = longint'(smooth_freq) + scaled_product(lfo, 64'(vib_depth), 15);
            mf  = scaled_product(cf, 64'(mod_ratio), 12);
            // A negative carrier frequency simply walks the phases backwards.
            carrier_phase = carrier_phase + 32'(scaled_product(cf, 64'(phase_per_hz), 16));
            mod_phase     = mod_phase + 32'(scaled_product(mf, 64'(phase_per_hz), 16));
            depth_idx = (64'(bright) * 64'(max_dev)) >> 16;
            s   = sine_of(mod_phase);
            dev = ((depth_idx * 64'((s < 0) ? -s : s)) >> 15) << 16;
            total = (s < 0) ? carrier_phase - 32'(dev) : carrier_phase + 32'(dev);
            v = sine_of(total);
            if (v > 32767) begin
                v = 32767;
            end
            if (v < -32767) begin
                v = -32767;
            end
            res.sample = 16'(v);
            res.last   = last;
            expected_q.push_back(res);
        endfunction

        function void check_sample(logic signed [15:0] sample, logic last);
            fm_result_t exp_res;
            if (expected_q.size() == 0) begin
                $error("sample beat with no expectation waiting: audio_sample %0d", sample);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            checked++;
            if (sample !== exp_res.sample) begin
                $error("audio_sample mismatch: expected %0d, got %0d", exp_res.sample, sample);
                errors++;
            end
            if (last !== exp_res.last) begin
                $error("block_last mismatch: expected %0b, got %0b", exp_res.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    fm_voice_scoreboard sb = new();

    bit no_idle_stretch = 1'b0;
    int ticks_sent      = 0;
    int block_ends      = 0;
    int settings_used   = 0;
    int results_seen    = 0;

    two_operator_fm_voice_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Each call leaves tvalid high; the caller lowers it with stop_ticks
    // in the same time step as the last handshake.
    task automatic send_tick(logic [15:0] pitch, logic [15:0] bright, logic last);
        while (!no_idle_stretch && $urandom_range(99) < 24) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bright, pitch};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_tick(pitch, bright, last);
        ticks_sent++;
        if (last) begin
            block_ends++;
        end
    endtask

    task automatic stop_ticks();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_for_samples();
        while (sb.pending() > 0) begin
            @(posedge i_clk);
        end
    endtask

    // Only called with the voice idle: every expected sample has arrived.
    task automatic program_voice(reg_set_t vals);
        t_cfg_idx idx;
        idx = idx.first();
        do begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= vals[int'(idx)];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.set_register(idx, vals[int'(idx)]);
            idx = idx.next();
        end while (idx != idx.first());
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [30:0] pick_register(t_cfg_idx idx);
        logic [30:0] mask;
        logic [30:0] musical;
        case (idx)
            CFG_BASE_FREQ:     begin
                mask = 31'h7FFF_FFFF;
                musical = 31'($urandom_range(2000 << 16, 20 << 16));
            end
            CFG_FREQ_SPAN:     begin
                mask = 31'h7FFF_FFFF;
                musical = 31'($urandom_range(4000 << 16, 0));
            end
            CFG_VIBRATO_DEPTH: begin
                mask = 31'h07FF_FFFF;
                musical = 31'($urandom_range(100 << 16, 0));
            end
            CFG_LFO_STEP:      begin
                mask = 31'h7FFF_FFFF;
                musical = 31'($urandom_range(1 << 24, 0));
            end
            CFG_MOD_RATIO:     begin
                mask = 31'h0000_FFFF;
                musical = 31'($urandom_range(16'hFFFF, 0));
            end
            CFG_MAX_DEVIATION: begin
                mask = 31'h000F_FFFF;
                musical = 31'($urandom_range(20'hF_FFFF, 0));
            end
            CFG_SMOOTH_COEFF:  begin
                mask = 31'h0000_FFFF;
                musical = 31'($urandom_range(4096, 0));
            end
            default:           begin
                mask = 31'h0001_FFFF;
                musical = 31'($urandom_range(110000, 80000));
            end
        endcase
        case ($urandom_range(9))
            0:       return '0;
            1:       return mask;
            2:       return 31'($urandom) & mask;
            default: return musical;
        endcase
    endfunction

    // The receiver decides its ready one cycle at a time, apart from one
    // long hold that lets the voice back up and stall its input.
    initial begin : sample_sink
        int hold_left;
        bit held_once;
        hold_left = 0;
        held_once = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                sb.check_sample($signed(m_axis_tdata), m_axis_tlast);
                results_seen++;
            end
            if (!held_once && results_seen >= HOLD_AT) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= no_idle_stretch || ($urandom_range(99) >= 24);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no beat for %0d cycles, %0d samples outstanding",
                 QUIET_LIMIT, sb.pending());
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        reg_set_t    vals;
        t_cfg_idx    idx;
        logic [15:0] held_pitch;
        logic [15:0] pitch;
        logic [15:0] bright;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default registers: control extremes and the block-end flag.
        send_tick(16'h0000, 16'h0000, 1'b0);
        send_tick(16'hFFFF, 16'hFFFF, 1'b1);
        send_tick(16'h0000, 16'hFFFF, 1'b0);
        send_tick(16'hFFFF, 16'h0000, 1'b1);
        send_tick(16'h8000, 16'h8000, 1'b0);
        send_tick(16'h0001, 16'h0001, 1'b1);
        stop_ticks();
        wait_for_samples();

        // Zero base and span with the deepest vibrato: the smoothed frequency
        // collapses and the carrier frequency swings negative.
        program_voice('{31'd0, 31'd0, 31'h07FF_FFFF, 31'h2000_0000,
                        31'h0000_FFFF, 31'h000F_FFFF, 31'h0000_FFFF, 31'h0001_FFFF});
        send_tick(16'h0000, 16'hFFFF, 1'b0);
        send_tick(16'h0000, 16'hFFFF, 1'b0);
        send_tick(16'h0000, 16'h0000, 1'b1);
        send_tick(16'hFFFF, 16'hFFFF, 1'b0);
        send_tick(16'h0000, 16'h5555, 1'b0);
        send_tick(16'h0000, 16'hAAAA, 1'b1);
        send_tick(16'h0000, 16'hFFFF, 1'b0);
        send_tick(16'h0000, 16'h7FFF, 1'b1);
        stop_ticks();
        wait_for_samples();

        // Widest base and span push the target towards its 32-bit ceiling.
        program_voice('{31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF,
                        31'd0, 31'd0, 31'h0000_FFFF, 31'd0});
        send_tick(16'hFFFF, 16'hFFFF, 1'b0);
        send_tick(16'hFFFF, 16'h0000, 1'b0);
        send_tick(16'hFFFF, 16'hFFFF, 1'b1);
        send_tick(16'h0000, 16'hFFFF, 1'b0);
        send_tick(16'hFFFF, 16'h1234, 1'b1);
        stop_ticks();
        wait_for_samples();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            idx = idx.first();
            do begin
                vals[int'(idx)] = pick_register(idx);
                idx = idx.next();
            end while (idx != idx.first());
            program_voice(vals);
            no_idle_stretch = (ph == 2);
            held_pitch = 16'($urandom);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                // Mostly held notes so the smoothing settles, with jumps and noise.
                if ($urandom_range(19) == 0) begin
                    held_pitch = ($urandom_range(3) == 0) ? {16{1'($urandom_range(1))}}
                                                          : 16'($urandom);
                end
                pitch  = ($urandom_range(7) == 0) ? 16'($urandom) : held_pitch;
                case ($urandom_range(7))
                    0:       bright = 16'h0000;
                    1:       bright = 16'hFFFF;
                    default: bright = 16'($urandom);
                endcase
                send_tick(pitch, bright, $urandom_range(15) == 0);
            end
            stop_ticks();
            wait_for_samples();
            no_idle_stretch = 1'b0;
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected samples never arrived", sb.pending());
            sb.errors++;
        end
        $display("Covered %0d ticks (%0d block ends) over %0d register settings,",
                 ticks_sent, block_ends, settings_used);
        $display("including negative carrier frequency and a full output stall; %0d checked.",
                 sb.checked);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/tofmv_pkg.sv
design/tofmv_datapath.sv
design/tofmv_ctrl.sv
design/two_operator_fm_voice_core.sv
tb/sv/tb_two_operator_fm_voice_core.sv
